[rtl/usbdrb_pkg.sv]
package usbdrb_pkg;

	localparam int NUM_ENDPOINTS = 16;
	localparam int EP_IDX_W = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
	localparam int NUM_PLAIN = 9;
	localparam int PLAIN_IDX_W = 4;

	localparam logic [2:0] OP_READ = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_XFER_DONE = 3'd2;
	localparam logic [2:0] OP_BUS_RESET = 3'd3;
	localparam logic [2:0] OP_FRAME_TICK = 3'd4;

	localparam logic [1:0] SUB_WRITE = 2'd0;
	localparam logic [1:0] SUB_CLEAR = 2'd1;
	localparam logic [1:0] SUB_SET = 2'd2;
	localparam logic [1:0] SUB_INVERT = 2'd3;

	localparam logic [5:0] REG_OTG_IRQ_FLAGS = 6'd0;
	localparam logic [5:0] REG_OTG_IRQ_ENABLE = 6'd1;
	localparam logic [5:0] REG_OTG_STATUS = 6'd2;
	localparam logic [5:0] REG_OTG_CONTROL = 6'd3;
	localparam logic [5:0] REG_POWER = 6'd4;
	localparam logic [5:0] REG_CORE_IRQ_FLAGS = 6'd5;
	localparam logic [5:0] REG_CORE_IRQ_ENABLE = 6'd6;
	localparam logic [5:0] REG_ERR_IRQ_FLAGS = 6'd7;
	localparam logic [5:0] REG_ERR_IRQ_ENABLE = 6'd8;
	localparam logic [5:0] REG_XFER_STATUS = 6'd9;
	localparam logic [5:0] REG_CONTROL = 6'd10;
	localparam logic [5:0] REG_ADDRESS = 6'd11;
	localparam logic [5:0] REG_BDT_PAGE1 = 6'd12;
	localparam logic [5:0] REG_FRAME_LOW = 6'd13;
	localparam logic [5:0] REG_FRAME_HIGH = 6'd14;
	localparam logic [5:0] REG_TOKEN = 6'd15;
	localparam logic [5:0] REG_SOF_THRESH = 6'd16;
	localparam logic [5:0] REG_BDT_PAGE2 = 6'd17;
	localparam logic [5:0] REG_BDT_PAGE3 = 6'd18;
	localparam logic [5:0] REG_CONFIG1 = 6'd19;
	localparam logic [5:0] REG_EP_BASE = 6'd20;

	localparam logic [PLAIN_IDX_W-1:0] PLAIN_NONE = 4'd15;
	localparam logic [PLAIN_IDX_W-1:0] PLAIN_SOF_SLOT = 4'd5;

	localparam logic [31:0] SOF_RESET = 32'h0000_004B;
	localparam logic [31:0] SESS_VLD_BIT = 32'h0000_0008;
	localparam logic [31:0] TRNIF_BIT = 32'h0000_0008;
	localparam logic [31:0] URSTIF_BIT = 32'h0000_0001;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [5:0]  reg_index;
		logic [1:0]  sub_op;
		logic [31:0] write_data;
		logic [3:0]  event_endpoint;
		logic        event_direction;
		logic        event_odd_buffer;
		logic [10:0] frame_advance;
	} usbdrb_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		logic        power_up_start;
	} usbdrb_rsp_t;

	function automatic logic [PLAIN_IDX_W-1:0] plain_slot(input logic [5:0] idx);
		logic [PLAIN_IDX_W-1:0] s;
		unique case (idx)
			REG_OTG_CONTROL: s = 4'd0;
			REG_CONTROL:     s = 4'd1;
			REG_ADDRESS:     s = 4'd2;
			REG_BDT_PAGE1:   s = 4'd3;
			REG_TOKEN:       s = 4'd4;
			REG_SOF_THRESH:  s = 4'd5;
			REG_BDT_PAGE2:   s = 4'd6;
			REG_BDT_PAGE3:   s = 4'd7;
			REG_CONFIG1:     s = 4'd8;
			default:         s = PLAIN_NONE;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] modify(input logic [31:0] old, input logic [31:0] v,
			input logic [1:0] sub);
		logic [31:0] r;
		unique case (sub)
			SUB_WRITE: r = v;
			SUB_CLEAR: r = old & ~v;
			SUB_SET:   r = old | v;
			SUB_INVERT: r = old ^ v;
			default:   r = old;
		endcase
		return r;
	endfunction

endpackage

[rtl/usb_device_register_block.sv]
// Each accepted request item moves from the input register to the response register.
// Throughput: one item per cycle unless a held response is stalled; input and response
// registers are separate stages. The register state updates when an item moves from the
// input stage to the response register, so each item sees all earlier items.
// Reset: async, active low; valid bits and state clear, start-of-frame threshold to 0x4B.
module usb_device_register_block (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  usbdrb_pkg::usbdrb_req_t req,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output usbdrb_pkg::usbdrb_rsp_t rsp
);

	logic                    valid_s1;
	usbdrb_pkg::usbdrb_req_t req_s1;
	logic                    out_valid_q;
	usbdrb_pkg::usbdrb_rsp_t rsp_q;
	usbdrb_pkg::usbdrb_rsp_t result;
	logic                    advance;

	assign advance = valid_s1 && (!out_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	usbdrb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (req_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!req_stall) valid_s1 <= req_valid;
			if (advance) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall) req_s1 <= req;
		if (advance) rsp_q <= result;
	end

	assign rsp_valid = out_valid_q;
	assign rsp = rsp_q;

endmodule

[rtl/usbdrb_core.sv]
module usbdrb_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  usbdrb_pkg::usbdrb_req_t item,
	output usbdrb_pkg::usbdrb_rsp_t result
);

	logic [31:0] otg_flags_q, otg_flags_d;
	logic [31:0] otg_en_q, otg_en_d;
	logic [31:0] otg_status_q, otg_status_d;
	logic [31:0] power_q, power_d;
	logic [31:0] core_flags_q, core_flags_d;
	logic [31:0] core_en_q, core_en_d;
	logic [31:0] err_flags_q, err_flags_d;
	logic [31:0] err_en_q, err_en_d;
	logic [31:0] xfer_status_q, xfer_status_d;
	logic [10:0] frame_q, frame_d;
	logic [31:0] plain_q [usbdrb_pkg::NUM_PLAIN];
	logic [31:0] plain_d [usbdrb_pkg::NUM_PLAIN];
	logic [31:0] ep_q [usbdrb_pkg::NUM_ENDPOINTS];
	logic [31:0] ep_d [usbdrb_pkg::NUM_ENDPOINTS];
	logic        attach_q, attach_d;

	logic [usbdrb_pkg::PLAIN_IDX_W-1:0] slot;
	logic [6:0]                         ep_off;
	logic                               ep_hit;
	logic [usbdrb_pkg::EP_IDX_W-1:0]    ep_sel;
	logic                               is_write;
	logic                               flag_clr;
	logic [31:0]                        rd;
	logic                               rise;

	assign slot = usbdrb_pkg::plain_slot(item.reg_index);
	assign ep_off = {1'b0, item.reg_index} - {1'b0, usbdrb_pkg::REG_EP_BASE};
	assign ep_hit = (item.reg_index >= usbdrb_pkg::REG_EP_BASE)
		&& ({1'b0, item.reg_index}
			< 7'(32'(usbdrb_pkg::REG_EP_BASE) + usbdrb_pkg::NUM_ENDPOINTS));
	assign ep_sel = ep_off[usbdrb_pkg::EP_IDX_W-1:0];
	assign is_write = (item.opcode == usbdrb_pkg::OP_WRITE);
	assign flag_clr = is_write && ((item.sub_op == usbdrb_pkg::SUB_WRITE)
		|| (item.sub_op == usbdrb_pkg::SUB_CLEAR));

	always_comb begin
		otg_flags_d = otg_flags_q;
		otg_en_d = otg_en_q;
		otg_status_d = otg_status_q;
		power_d = power_q;
		core_flags_d = core_flags_q;
		core_en_d = core_en_q;
		err_flags_d = err_flags_q;
		err_en_d = err_en_q;
		xfer_status_d = xfer_status_q;
		frame_d = frame_q;
		plain_d = plain_q;
		ep_d = ep_q;
		attach_d = attach_q;
		rise = 1'b0;
		if (is_write) begin
			if (item.reg_index == usbdrb_pkg::REG_OTG_IRQ_FLAGS) begin
				if (flag_clr) otg_flags_d = otg_flags_q & ~item.write_data;
			end else if (item.reg_index == usbdrb_pkg::REG_OTG_IRQ_ENABLE) begin
				otg_en_d = usbdrb_pkg::modify(otg_en_q, item.write_data, item.sub_op);
			end else if (item.reg_index == usbdrb_pkg::REG_POWER) begin
				power_d = usbdrb_pkg::modify(power_q, item.write_data, item.sub_op);
				rise = power_d[0] && !power_q[0] && !attach_q;
				if (rise) attach_d = 1'b1;
			end else if (item.reg_index == usbdrb_pkg::REG_CORE_IRQ_FLAGS) begin
				if (flag_clr) core_flags_d = core_flags_q & ~item.write_data;
			end else if (item.reg_index == usbdrb_pkg::REG_CORE_IRQ_ENABLE) begin
				core_en_d = usbdrb_pkg::modify(core_en_q, item.write_data, item.sub_op);
			end else if (item.reg_index == usbdrb_pkg::REG_ERR_IRQ_FLAGS) begin
				if (flag_clr) err_flags_d = err_flags_q & ~item.write_data;
			end else if (item.reg_index == usbdrb_pkg::REG_ERR_IRQ_ENABLE) begin
				err_en_d = usbdrb_pkg::modify(err_en_q, item.write_data, item.sub_op);
			end else if (slot != usbdrb_pkg::PLAIN_NONE) begin
				plain_d[slot] = usbdrb_pkg::modify(plain_q[slot], item.write_data,
					item.sub_op);
			end else if (ep_hit) begin
				ep_d[ep_sel] = usbdrb_pkg::modify(ep_q[ep_sel], item.write_data,
					item.sub_op);
			end
		end else if (item.opcode == usbdrb_pkg::OP_XFER_DONE) begin
			xfer_status_d = {24'b0, item.event_endpoint, item.event_direction,
				item.event_odd_buffer, 2'b0};
			core_flags_d = core_flags_q | usbdrb_pkg::TRNIF_BIT;
		end else if (item.opcode == usbdrb_pkg::OP_BUS_RESET) begin
			otg_status_d = otg_status_q | usbdrb_pkg::SESS_VLD_BIT;
			otg_flags_d = otg_flags_q | usbdrb_pkg::SESS_VLD_BIT;
			core_flags_d = core_flags_q | usbdrb_pkg::URSTIF_BIT;
		end else if (item.opcode == usbdrb_pkg::OP_FRAME_TICK) begin
			frame_d = frame_q + item.frame_advance;
		end
	end

	always_comb begin
		rd = '0;
		if (item.opcode == usbdrb_pkg::OP_READ) begin
			if (item.reg_index == usbdrb_pkg::REG_OTG_IRQ_FLAGS) rd = otg_flags_q;
			else if (item.reg_index == usbdrb_pkg::REG_OTG_IRQ_ENABLE) rd = otg_en_q;
			else if (item.reg_index == usbdrb_pkg::REG_OTG_STATUS) rd = otg_status_q;
			else if (item.reg_index == usbdrb_pkg::REG_POWER) rd = power_q;
			else if (item.reg_index == usbdrb_pkg::REG_CORE_IRQ_FLAGS) rd = core_flags_q;
			else if (item.reg_index == usbdrb_pkg::REG_CORE_IRQ_ENABLE) rd = core_en_q;
			else if (item.reg_index == usbdrb_pkg::REG_ERR_IRQ_FLAGS) rd = err_flags_q;
			else if (item.reg_index == usbdrb_pkg::REG_ERR_IRQ_ENABLE) rd = err_en_q;
			else if (item.reg_index == usbdrb_pkg::REG_XFER_STATUS) rd = xfer_status_q;
			else if (item.reg_index == usbdrb_pkg::REG_FRAME_LOW) rd = {24'b0, frame_q[7:0]};
			else if (item.reg_index == usbdrb_pkg::REG_FRAME_HIGH) rd = {29'b0, frame_q[10:8]};
			else if (slot != usbdrb_pkg::PLAIN_NONE) rd = plain_q[slot];
			else if (ep_hit) rd = ep_q[ep_sel];
		end
	end

	always_comb begin
		result.read_data = rd;
		result.irq = ((core_flags_d & core_en_d) != '0)
			|| ((err_flags_d & err_en_d) != '0)
			|| ((otg_flags_d & otg_en_d) != '0);
		result.power_up_start = rise;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			otg_flags_q <= '0;
			otg_en_q <= '0;
			otg_status_q <= '0;
			power_q <= '0;
			core_flags_q <= '0;
			core_en_q <= '0;
			err_flags_q <= '0;
			err_en_q <= '0;
			xfer_status_q <= '0;
			frame_q <= '0;
			for (int i = 0; i < usbdrb_pkg::NUM_PLAIN; i++) begin
				plain_q[i] <= (i == 32'(usbdrb_pkg::PLAIN_SOF_SLOT))
					? usbdrb_pkg::SOF_RESET : '0;
			end
			for (int i = 0; i < usbdrb_pkg::NUM_ENDPOINTS; i++) begin
				ep_q[i] <= '0;
			end
			attach_q <= 1'b0;
		end else if (en) begin
			otg_flags_q <= otg_flags_d;
			otg_en_q <= otg_en_d;
			otg_status_q <= otg_status_d;
			power_q <= power_d;
			core_flags_q <= core_flags_d;
			core_en_q <= core_en_d;
			err_flags_q <= err_flags_d;
			err_en_q <= err_en_d;
			xfer_status_q <= xfer_status_d;
			frame_q <= frame_d;
			plain_q <= plain_d;
			ep_q <= ep_d;
			attach_q <= attach_d;
		end
	end

	a_attach_once: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(attach_q) |-> $past(en && result.power_up_start))
		else $error("attach flag set without a reported power rise");

	a_frame_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(frame_q) |-> $past(en && item.opcode == usbdrb_pkg::OP_FRAME_TICK))
		else $error("frame number moved without a frame tick");

	a_trnif_set: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.opcode == usbdrb_pkg::OP_XFER_DONE
		|=> (core_flags_q & usbdrb_pkg::TRNIF_BIT) != '0)
		else $error("transfer done did not raise TRNIF");

	a_no_second_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$past(attach_q) && attach_q |-> !(en && result.power_up_start))
		else $error("power rise reported twice");

endmodule

[test/usb_device_register_block_checker.sv]
`timescale 1ns / 100ps
module usb_device_register_block_checker
	import usbdrb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  usbdrb_req_t req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  usbdrb_rsp_t rsp,
	output int          pending,
	output int          fail_count
);

	localparam int POWER_BIT = 0;

	logic [31:0] otg_flags, otg_enable, otg_status, power_ctl;
	logic [31:0] core_flags, core_enable, err_flags, err_enable, xfer_status;
	logic [10:0] frame_num;
	logic [31:0] plain_bank [0:63];
	logic [31:0] ep_ctrl [0:NUM_ENDPOINTS-1];
	logic        attached;
	usbdrb_rsp_t expected_rsp [$];

	function automatic bit is_plain(input logic [5:0] idx);
		case (idx)
			REG_OTG_CONTROL, REG_CONTROL, REG_ADDRESS, REG_BDT_PAGE1, REG_TOKEN,
			REG_SOF_THRESH, REG_BDT_PAGE2, REG_BDT_PAGE3, REG_CONFIG1: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit is_endpoint(input logic [5:0] idx);
		return idx >= REG_EP_BASE && int'(idx) < int'(REG_EP_BASE) + NUM_ENDPOINTS;
	endfunction

	function automatic logic [31:0] bit_update(input logic [31:0] cur, input logic [31:0] v,
			input logic [1:0] sub);
		case (sub)
			SUB_WRITE: return v;
			SUB_CLEAR: return cur & ~v;
			SUB_SET:   return cur | v;
			default:   return cur ^ v;
		endcase
	endfunction

	function automatic logic [31:0] flag_clear(input logic [31:0] cur, input logic [31:0] v,
			input logic [1:0] sub);
		if (sub == SUB_WRITE || sub == SUB_CLEAR)
			return cur & ~v;
		return cur;
	endfunction

	function automatic logic [31:0] register_value(input logic [5:0] idx);
		case (idx)
			REG_OTG_IRQ_FLAGS:   return otg_flags;
			REG_OTG_IRQ_ENABLE:  return otg_enable;
			REG_OTG_STATUS:      return otg_status;
			REG_POWER:           return power_ctl;
			REG_CORE_IRQ_FLAGS:  return core_flags;
			REG_CORE_IRQ_ENABLE: return core_enable;
			REG_ERR_IRQ_FLAGS:   return err_flags;
			REG_ERR_IRQ_ENABLE:  return err_enable;
			REG_XFER_STATUS:     return xfer_status;
			REG_FRAME_LOW:       return {24'd0, frame_num[7:0]};
			REG_FRAME_HIGH:      return {29'd0, frame_num[10:8]};
			default: begin
				if (is_plain(idx))
					return plain_bank[idx];
				if (is_endpoint(idx))
					return ep_ctrl[EP_IDX_W'(idx - REG_EP_BASE)];
				return '0;
			end
		endcase
	endfunction

	function automatic void register_write(input logic [5:0] idx, input logic [1:0] sub,
			input logic [31:0] v);
		logic [EP_IDX_W-1:0] ep;
		ep = EP_IDX_W'(idx - REG_EP_BASE);
		case (idx)
			REG_OTG_IRQ_FLAGS:   otg_flags = flag_clear(otg_flags, v, sub);
			REG_OTG_IRQ_ENABLE:  otg_enable = bit_update(otg_enable, v, sub);
			REG_POWER:           power_ctl = bit_update(power_ctl, v, sub);
			REG_CORE_IRQ_FLAGS:  core_flags = flag_clear(core_flags, v, sub);
			REG_CORE_IRQ_ENABLE: core_enable = bit_update(core_enable, v, sub);
			REG_ERR_IRQ_FLAGS:   err_flags = flag_clear(err_flags, v, sub);
			REG_ERR_IRQ_ENABLE:  err_enable = bit_update(err_enable, v, sub);
			default: begin
				if (is_plain(idx))
					plain_bank[idx] = bit_update(plain_bank[idx], v, sub);
				else if (is_endpoint(idx))
					ep_ctrl[ep] = bit_update(ep_ctrl[ep], v, sub);
			end
		endcase
	endfunction

	function automatic usbdrb_rsp_t register_access(input usbdrb_req_t r);
		usbdrb_rsp_t e;
		logic        was_powered;
		e = '0;
		case (r.opcode)
			OP_READ: e.read_data = register_value(r.reg_index);
			OP_WRITE: begin
				was_powered = power_ctl[POWER_BIT];
				register_write(r.reg_index, r.sub_op, r.write_data);
				if (power_ctl[POWER_BIT] && !was_powered && !attached) begin
					attached = 1'b1;
					e.power_up_start = 1'b1;
				end
			end
			OP_XFER_DONE: begin
				xfer_status = {24'd0, r.event_endpoint, r.event_direction,
					r.event_odd_buffer, 2'b00};
				core_flags = core_flags | TRNIF_BIT;
			end
			OP_BUS_RESET: begin
				otg_status = otg_status | SESS_VLD_BIT;
				otg_flags = otg_flags | SESS_VLD_BIT;
				core_flags = core_flags | URSTIF_BIT;
			end
			OP_FRAME_TICK: frame_num = frame_num + r.frame_advance;
			default: ;
		endcase
		e.irq = |(core_flags & core_enable) || |(err_flags & err_enable)
			|| |(otg_flags & otg_enable);
		return e;
	endfunction

	task automatic compare_response(input usbdrb_rsp_t got);
		usbdrb_rsp_t want;
		if (expected_rsp.size() == 0) begin
			$error("response item with none expected: %h", got);
			fail_count++;
		end else begin
			want = expected_rsp.pop_front();
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %h, actual %h", want.read_data, got.read_data);
				fail_count++;
			end
			if (got.irq !== want.irq) begin
				$error("irq: expected %b, actual %b", want.irq, got.irq);
				fail_count++;
			end
			if (got.power_up_start !== want.power_up_start) begin
				$error("power_up_start: expected %b, actual %b", want.power_up_start,
					got.power_up_start);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			otg_flags = '0;
			otg_enable = '0;
			otg_status = '0;
			power_ctl = '0;
			core_flags = '0;
			core_enable = '0;
			err_flags = '0;
			err_enable = '0;
			xfer_status = '0;
			frame_num = '0;
			for (int i = 0; i < 64; i++)
				plain_bank[i] = '0;
			plain_bank[REG_SOF_THRESH] = SOF_RESET;
			for (int i = 0; i < NUM_ENDPOINTS; i++)
				ep_ctrl[i] = '0;
			attached = 1'b0;
			expected_rsp.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				compare_response(rsp);
			if (req_valid && !req_stall)
				expected_rsp.push_back(register_access(req));
			pending = expected_rsp.size();
		end
	end

endmodule

[test/usb_device_register_block_tb.sv]
`timescale 1ns / 100ps
module usb_device_register_block_tb;
	import usbdrb_pkg::*;

	localparam int RESET_CYCLES = 7;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEMS_PER_PHASE = 130;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [5:0] REG_UNIMPL = 6'd63;
	localparam logic [5:0] REG_EP_LAST = REG_EP_BASE + 6'(NUM_ENDPOINTS - 1);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	usbdrb_req_t req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	usbdrb_rsp_t rsp;
	int          pending;
	int          fail_count;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	usb_device_register_block u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	usb_device_register_block_checker u_check (.*);

	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_item(input usbdrb_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send_access(input logic [2:0] op, input logic [5:0] idx,
			input logic [1:0] sub, input logic [31:0] data);
		usbdrb_req_t r;
		r = '0;
		r.opcode = op;
		r.reg_index = idx;
		r.sub_op = sub;
		r.write_data = data;
		send_item(r);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic usbdrb_req_t random_item();
		usbdrb_req_t r;
		int          pick;
		r.sub_op = 2'($urandom_range(3));
		r.event_endpoint = 4'($urandom_range(15));
		r.event_direction = 1'($urandom_range(1));
		r.event_odd_buffer = 1'($urandom_range(1));
		r.frame_advance = 11'($urandom_range(2047));
		r.reg_index = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(35));
		pick = $urandom_range(9);
		r.write_data = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
		pick = $urandom_range(99);
		if (pick < 30)
			r.opcode = OP_READ;
		else if (pick < 70)
			r.opcode = OP_WRITE;
		else if (pick < 78)
			r.opcode = OP_XFER_DONE;
		else if (pick < 84)
			r.opcode = OP_BUS_RESET;
		else if (pick < 96)
			r.opcode = OP_FRAME_TICK;
		else
			r.opcode = 3'($urandom_range(5, 7));
		return r;
	endfunction

	initial begin
		usbdrb_req_t r;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_access(OP_READ, REG_SOF_THRESH, SUB_WRITE, '0);
		send_access(OP_READ, REG_FRAME_LOW, SUB_WRITE, '0);
		send_access(OP_WRITE, REG_OTG_IRQ_ENABLE, SUB_WRITE, '1);
		send_access(OP_WRITE, REG_ERR_IRQ_ENABLE, SUB_WRITE, '1);
		send_access(OP_BUS_RESET, REG_OTG_IRQ_FLAGS, SUB_WRITE, '0);
		send_access(OP_WRITE, REG_OTG_IRQ_FLAGS, SUB_SET, '1);
		send_access(OP_WRITE, REG_OTG_IRQ_FLAGS, SUB_INVERT, '1);
		send_access(OP_READ, REG_OTG_IRQ_FLAGS, SUB_WRITE, '0);
		send_access(OP_WRITE, REG_OTG_IRQ_FLAGS, SUB_CLEAR, SESS_VLD_BIT);
		send_access(OP_WRITE, REG_CORE_IRQ_ENABLE, SUB_SET, TRNIF_BIT | URSTIF_BIT);
		r = '0;
		r.opcode = OP_XFER_DONE;
		r.event_endpoint = '1;
		r.event_direction = 1'b1;
		r.event_odd_buffer = 1'b1;
		send_item(r);
		send_access(OP_READ, REG_XFER_STATUS, SUB_WRITE, '0);
		send_access(OP_WRITE, REG_CORE_IRQ_FLAGS, SUB_WRITE, '1);
		send_access(OP_WRITE, REG_POWER, SUB_SET, 32'd1);
		send_access(OP_WRITE, REG_POWER, SUB_CLEAR, '1);
		send_access(OP_WRITE, REG_POWER, SUB_INVERT, 32'd1);
		r = '0;
		r.opcode = OP_FRAME_TICK;
		r.frame_advance = '1;
		send_item(r);
		r.frame_advance = 11'd5;
		send_item(r);
		send_access(OP_READ, REG_FRAME_HIGH, SUB_WRITE, '0);
		send_access(OP_WRITE, REG_OTG_STATUS, SUB_WRITE, '1);
		send_access(OP_READ, REG_OTG_STATUS, SUB_WRITE, '0);
		send_access(OP_WRITE, REG_UNIMPL, SUB_WRITE, '1);
		send_access(OP_READ, REG_UNIMPL, SUB_WRITE, '0);
		send_access(OP_WRITE, REG_EP_LAST, SUB_INVERT, '1);
		send_access(OP_READ, REG_EP_LAST, SUB_WRITE, '0);
		send_access(OP_UNUSED, REG_SOF_THRESH, SUB_WRITE, '1);

		send_idle = 33;
		recv_idle = 69;
		repeat (ITEMS_PER_PHASE) send_item(random_item());
		wait_for_results();

		send_idle = 69;
		recv_idle = 33;
		repeat (ITEMS_PER_PHASE) send_item(random_item());

		send_idle = 0;
		recv_idle = 0;
		repeat (ITEMS_PER_PHASE) send_item(random_item());

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
